// ===== rtl/assert_macros.svh =====
// assertion macros shared by the sniffer rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked every cycle outside reset
`define FTS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition in one cycle implies a result in the next
`define FTS_ASSERT_NEXT(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (prop)) else $error(msg);

`endif

// ===== rtl/fts_pkg.sv =====
// types, codes and match tables of the file type sniffer
package fts_pkg;

  localparam int HEAD_BYTES_DEF = 512;

  localparam int KIND_W = 2;
  localparam int MODE_W = 2;
  localparam int TYPE_W = 5;

  localparam logic [KIND_W-1:0] KIND_BEGIN = 2'd0;
  localparam logic [KIND_W-1:0] KIND_BYTE  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_END   = 2'd2;

  localparam logic [MODE_W-1:0] MODE_EXT_ONLY     = 2'd1;
  localparam logic [MODE_W-1:0] MODE_CONTENT_ONLY = 2'd2;

  localparam logic [TYPE_W-1:0] TYPE_SVG     = 5'd7;
  localparam logic [TYPE_W-1:0] TYPE_TEXT    = 5'd8;
  localparam logic [TYPE_W-1:0] TYPE_UNKNOWN = 5'd17;

  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_CR    = 8'h0d;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_LT    = 8'h3c;

  localparam logic [2:0] SVG_LEN     = 3'd4;
  localparam logic [3:0] PREFIX_FULL = 4'd8;

  localparam int SUFFIX_N = 23;
  localparam int MAGIC_N  = 11;

  localparam logic [31:0] SUFFIX_CHARS [SUFFIX_N] = '{
    32'h70646600, 32'h70730000, 32'h6a706700, 32'h6a706567, 32'h6a706500,
    32'h706e6700, 32'h67696600, 32'h74696600, 32'h74696666, 32'h626d7000,
    32'h73766700, 32'h74787400, 32'h74657874, 32'h6c6f6700, 32'h6d640000,
    32'h63737600, 32'h646f6300, 32'h646f6378, 32'h72746600, 32'h6f647400,
    32'h70707400, 32'h70707478, 32'h6f647000
  };
  localparam logic [2:0] SUFFIX_LEN [SUFFIX_N] = '{
    3'd3, 3'd2, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3,
    3'd4, 3'd3, 3'd2, 3'd3, 3'd3, 3'd4, 3'd3, 3'd3, 3'd3, 3'd4, 3'd3
  };
  localparam logic [TYPE_W-1:0] SUFFIX_TYPE [SUFFIX_N] = '{
    5'd0, 5'd1, 5'd2, 5'd2, 5'd2, 5'd3, 5'd4, 5'd5, 5'd5, 5'd6, 5'd7, 5'd8,
    5'd8, 5'd8, 5'd8, 5'd9, 5'd10, 5'd11, 5'd12, 5'd13, 5'd14, 5'd15, 5'd16
  };

  localparam logic [63:0] MAGIC_PAT [MAGIC_N] = '{
    64'h2550444600000000, 64'h2521505300000000, 64'hffd8ff0000000000,
    64'h89504e470d0a1a0a, 64'h4749463837610000, 64'h4749463839610000,
    64'h49492a0000000000, 64'h4d4d002a00000000, 64'h424d000000000000,
    64'h7b5c727466000000, 64'hd0cf11e000000000
  };
  localparam logic [3:0] MAGIC_LEN [MAGIC_N] = '{
    4'd4, 4'd4, 4'd3, 4'd8, 4'd6, 4'd6, 4'd4, 4'd4, 4'd2, 4'd5, 4'd4
  };
  localparam logic [TYPE_W-1:0] MAGIC_TYPE [MAGIC_N] = '{
    5'd0, 5'd1, 5'd2, 5'd3, 5'd4, 5'd4, 5'd5, 5'd5, 5'd6, 5'd12, 5'd10
  };

  // what the head tracker knows about the bytes seen so far
  typedef struct packed {
    logic [63:0] prefix;
    logic [3:0]  prefix_cnt;
    logic        any;
    logic        svg_seen;
    logic        text_clean;
  } head_status_t;

  function automatic logic [7:0] svg_char(input logic [1:0] idx);
    logic [7:0] c;
    unique case (idx)
      2'd0: c = 8'h3c;
      2'd1: c = 8'h73;
      2'd2: c = 8'h76;
      default: c = 8'h67;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/fts_suffix_match.sv =====
// suffix table lookup for the begin request
module fts_suffix_match (
  input  logic [31:0]                suffix_chars,
  input  logic [2:0]                 suffix_len,
  output logic [fts_pkg::TYPE_W-1:0] suffix_type
);
  import fts_pkg::*;

  logic [31:0] mask;
  logic        len_ok;

  always_comb begin
    len_ok = 1'b1;
    unique case (suffix_len)
      3'd1: mask = 32'hff000000;
      3'd2: mask = 32'hffff0000;
      3'd3: mask = 32'hffffff00;
      3'd4: mask = 32'hffffffff;
      default: begin
        mask   = 32'h0;
        len_ok = 1'b0;
      end
    endcase
  end

  // scan from the back so the earliest entry wins
  always_comb begin
    suffix_type = TYPE_UNKNOWN;
    for (int i = SUFFIX_N - 1; i >= 0; i--) begin
      if (len_ok && SUFFIX_LEN[i] == suffix_len &&
          (suffix_chars & mask) == SUFFIX_CHARS[i]) begin
        suffix_type = SUFFIX_TYPE[i];
      end
    end
  end

endmodule

// ===== rtl/fts_head_track.sv =====
// head byte state: prefix capture, svg search, text check, byte count
module fts_head_track #(
  parameter int HEAD_BYTES = fts_pkg::HEAD_BYTES_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  clear,
  input  logic                  take,
  input  logic [7:0]            data_byte,
  output fts_pkg::head_status_t status
);
  import fts_pkg::*;

  localparam int CNT_W = $clog2(HEAD_BYTES + 1);
  localparam logic [CNT_W-1:0] HEAD_MAX = CNT_W'(HEAD_BYTES);
  localparam logic [CNT_W-1:0] PREFIX_MAX = CNT_W'(8);

  logic [CNT_W-1:0] bytes_seen, bytes_seen_next;
  logic [63:0]      head_prefix, head_prefix_next;
  logic [2:0]       svg_progress, svg_progress_next;
  logic             svg_seen, svg_seen_next;
  logic             text_clean, text_clean_next;

  logic             room;
  logic             ctrl_byte;

  assign room      = bytes_seen < HEAD_MAX;
  assign ctrl_byte = data_byte < CHAR_TAB || (data_byte > CHAR_CR && data_byte < CHAR_SPACE);

  always_comb begin
    bytes_seen_next   = bytes_seen;
    head_prefix_next  = head_prefix;
    svg_progress_next = svg_progress;
    svg_seen_next     = svg_seen;
    text_clean_next   = text_clean;
    if (clear) begin
      bytes_seen_next   = '0;
      head_prefix_next  = '0;
      svg_progress_next = '0;
      svg_seen_next     = 1'b0;
      text_clean_next   = 1'b1;
    end else if (take && room) begin
      bytes_seen_next = bytes_seen + 1'b1;
      if (bytes_seen < PREFIX_MAX) begin
        head_prefix_next = head_prefix |
                           ({data_byte, 56'h0} >> {bytes_seen[2:0], 3'b000});
      end
      if (ctrl_byte) begin
        text_clean_next = 1'b0;
      end
      if (!svg_seen) begin
        if (svg_progress < SVG_LEN && data_byte == svg_char(svg_progress[1:0])) begin
          svg_progress_next = svg_progress + 1'b1;
        end else begin
          svg_progress_next = (data_byte == CHAR_LT) ? 3'd1 : 3'd0;
        end
        svg_seen_next = (svg_progress_next >= SVG_LEN);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_seen   <= '0;
      head_prefix  <= '0;
      svg_progress <= '0;
      svg_seen     <= 1'b0;
      text_clean   <= 1'b1;
    end else begin
      bytes_seen   <= bytes_seen_next;
      head_prefix  <= head_prefix_next;
      svg_progress <= svg_progress_next;
      svg_seen     <= svg_seen_next;
      text_clean   <= text_clean_next;
    end
  end

  assign status.prefix     = head_prefix;
  assign status.prefix_cnt = (bytes_seen >= PREFIX_MAX) ? PREFIX_FULL : 4'(bytes_seen);
  assign status.any        = bytes_seen != '0;
  assign status.svg_seen   = svg_seen;
  assign status.text_clean = text_clean;

`include "assert_macros.svh"

  `FTS_ASSERT(a_count_bound, bytes_seen <= HEAD_MAX, "byte count passed head size")
  `FTS_ASSERT(a_svg_done, !svg_seen || svg_progress == SVG_LEN, "svg flag without full match")
  `FTS_ASSERT(a_empty_prefix, bytes_seen != '0 || head_prefix == '0, "prefix set on empty head")

endmodule

// ===== rtl/fts_classify.sv =====
// final type decision from suffix result and head status
module fts_classify (
  input  logic [fts_pkg::MODE_W-1:0] mode_held,
  input  logic [fts_pkg::TYPE_W-1:0] suffix_type,
  input  fts_pkg::head_status_t      status,
  output logic [fts_pkg::TYPE_W-1:0] type_code
);
  import fts_pkg::*;

  logic [63:0]       mask;
  logic              magic_hit;
  logic [TYPE_W-1:0] magic_type;

  always_comb begin
    magic_hit  = 1'b0;
    magic_type = TYPE_UNKNOWN;
    mask       = '0;
    for (int i = MAGIC_N - 1; i >= 0; i--) begin
      mask = (MAGIC_LEN[i] >= 4'd8) ? {64{1'b1}} :
             ~({64{1'b1}} >> {MAGIC_LEN[i][2:0], 3'b000});
      if (status.prefix_cnt >= MAGIC_LEN[i] && (status.prefix & mask) == MAGIC_PAT[i]) begin
        magic_hit  = 1'b1;
        magic_type = MAGIC_TYPE[i];
      end
    end
  end

  always_comb begin
    if (suffix_type != TYPE_UNKNOWN) begin
      type_code = suffix_type;
    end else if (mode_held == MODE_EXT_ONLY) begin
      type_code = TYPE_UNKNOWN;
    end else if (magic_hit) begin
      type_code = magic_type;
    end else if (status.svg_seen) begin
      type_code = TYPE_SVG;
    end else if (!status.any) begin
      type_code = TYPE_UNKNOWN;
    end else if (status.text_clean) begin
      type_code = TYPE_TEXT;
    end else begin
      type_code = TYPE_UNKNOWN;
    end
  end

endmodule

// ===== rtl/file_type_sniffer_core.sv =====
// top level of the file type sniffer
//
//   channel  | handshake           | payload
//   ---------+---------------------+--------------------------------------------
//   input    | in_valid, in_stall  | kind, match_mode, suffix_chars, suffix_len,
//            |                     | data_byte
//   result   | out_valid, out_stall| type_code
//
// one request per cycle while in_stall is low, and each end request gets a registered result:
// a request sits in the input register, then updates the state
// registers, and an end request loads the result register in that same step
// rst clears the input and result valid bits and all head state
// in_stall rises only while an end request waits in the input register and
// the result register still holds an untaken result
module file_type_sniffer_core #(
  parameter int HEAD_BYTES = fts_pkg::HEAD_BYTES_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [fts_pkg::KIND_W-1:0] kind,
  input  logic [fts_pkg::MODE_W-1:0] match_mode,
  input  logic [31:0]                suffix_chars,
  input  logic [2:0]                 suffix_len,
  input  logic [7:0]                 data_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [fts_pkg::TYPE_W-1:0] type_code
);
  import fts_pkg::*;

  // input register
  logic              s1_valid;
  logic [KIND_W-1:0] s1_kind;
  logic [MODE_W-1:0] s1_mode;
  logic [31:0]       s1_chars;
  logic [2:0]        s1_len;
  logic [7:0]        s1_byte;

  // per-file decision state
  logic [MODE_W-1:0] mode_held, mode_held_next;
  logic [TYPE_W-1:0] suffix_type, suffix_type_next;

  logic              in_take;
  logic              s1_adv;
  logic              s1_begin, s1_data, s1_end;
  logic [TYPE_W-1:0] lookup_type;
  logic [TYPE_W-1:0] decided_type;
  head_status_t      head_status;

  assign s1_begin = s1_valid && s1_kind == KIND_BEGIN;
  assign s1_data  = s1_valid && s1_kind == KIND_BYTE;
  assign s1_end   = s1_valid && s1_kind == KIND_END;

  // only an end request needs the result register free
  assign s1_adv   = s1_valid && !(s1_end && out_valid && out_stall);
  assign in_stall = s1_valid && !s1_adv;
  assign in_take  = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_take) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_kind  <= kind;
      s1_mode  <= match_mode;
      s1_chars <= suffix_chars;
      s1_len   <= suffix_len;
      s1_byte  <= data_byte;
    end
  end

  fts_suffix_match u_suffix (
    .suffix_chars (s1_chars),
    .suffix_len   (s1_len),
    .suffix_type  (lookup_type)
  );

  // begin latches the mode and the suffix verdict, content-only skips the table
  always_comb begin
    mode_held_next   = mode_held;
    suffix_type_next = suffix_type;
    if (s1_begin) begin
      mode_held_next   = s1_mode;
      suffix_type_next = (s1_mode == MODE_CONTENT_ONLY) ? TYPE_UNKNOWN : lookup_type;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_held   <= '0;
      suffix_type <= TYPE_UNKNOWN;
    end else begin
      mode_held   <= mode_held_next;
      suffix_type <= suffix_type_next;
    end
  end

  fts_head_track #(
    .HEAD_BYTES (HEAD_BYTES)
  ) u_head (
    .clk       (clk),
    .rst       (rst),
    .clear     (s1_begin),
    .take      (s1_data),
    .data_byte (s1_byte),
    .status    (head_status)
  );

  fts_classify u_classify (
    .mode_held   (mode_held),
    .suffix_type (suffix_type),
    .status      (head_status),
    .type_code   (decided_type)
  );

  // result register, refilled when its end request leaves the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_end && s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_end && s1_adv) begin
      type_code <= decided_type;
    end
  end

`include "assert_macros.svh"

  `FTS_ASSERT_NEXT(a_end_gives_result, s1_end && s1_adv, out_valid, "end request lost its result")
  `FTS_ASSERT(a_stall_cause, !in_stall || (s1_end && out_valid && out_stall),
              "input stalled without a blocked result")
  `FTS_ASSERT(a_content_only, mode_held != MODE_CONTENT_ONLY || suffix_type == TYPE_UNKNOWN,
              "suffix verdict kept in content-only mode")

endmodule

// ===== verif/tb_sniff_pkg.sv =====
// scoreboard and file type predictor for the sniffer testbench
`timescale 1ns / 1ps
package tb_sniff_pkg;

  typedef enum logic [4:0] {
    FT_PDF, FT_PS, FT_JPEG, FT_PNG, FT_GIF, FT_TIFF, FT_BMP, FT_SVG, FT_TEXT, FT_CSV,
    FT_MSWORD, FT_DOCX, FT_RTF, FT_ODT, FT_PPT, FT_PPTX, FT_ODP, FT_UNKNOWN
  } file_type_e;

  localparam logic [1:0] MODE_DEFAULT = 2'd0;
  localparam logic [1:0] MODE_BOTH    = 2'd3;
  localparam logic [1:0] KIND_SPARE   = 2'd3;

  localparam logic [31:0] SVG_TAG = "<svg";

  class sniff_scoreboard;
    int unsigned head_limit;
    int unsigned errors;
    logic [1:0]  mode_q;
    file_type_e  suffix_hit;
    int unsigned head_count;
    logic [63:0] head_first;
    logic [2:0]  svg_step;
    bit          svg_found;
    bit          printable;
    file_type_e  expected_types[$];

    function new(int unsigned limit);
      head_limit = limit;
      errors     = 0;
      mode_q     = MODE_DEFAULT;
      suffix_hit = FT_UNKNOWN;
      clear_head();
    endfunction

    function void clear_head();
      head_count = 0;
      head_first = '0;
      svg_step   = '0;
      svg_found  = 1'b0;
      printable  = 1'b1;
    endfunction

    function file_type_e suffix_lookup(logic [31:0] chars, logic [2:0] len);
      logic [31:0] kept;
      file_type_e  hit;
      hit = FT_UNKNOWN;
      if (len == 0 || len > 4) return FT_UNKNOWN;
      kept = chars & ~(32'hffff_ffff >> (8 * len));
      case (len)
        3'd2: begin
          case (kept)
            {"ps", 16'h0}: hit = FT_PS;
            {"md", 16'h0}: hit = FT_TEXT;
            default: ;
          endcase
        end
        3'd3: begin
          case (kept)
            {"pdf", 8'h0}: hit = FT_PDF;
            {"jpg", 8'h0}: hit = FT_JPEG;
            {"jpe", 8'h0}: hit = FT_JPEG;
            {"png", 8'h0}: hit = FT_PNG;
            {"gif", 8'h0}: hit = FT_GIF;
            {"tif", 8'h0}: hit = FT_TIFF;
            {"bmp", 8'h0}: hit = FT_BMP;
            {"svg", 8'h0}: hit = FT_SVG;
            {"txt", 8'h0}: hit = FT_TEXT;
            {"log", 8'h0}: hit = FT_TEXT;
            {"csv", 8'h0}: hit = FT_CSV;
            {"doc", 8'h0}: hit = FT_MSWORD;
            {"rtf", 8'h0}: hit = FT_RTF;
            {"odt", 8'h0}: hit = FT_ODT;
            {"ppt", 8'h0}: hit = FT_PPT;
            {"odp", 8'h0}: hit = FT_ODP;
            default: ;
          endcase
        end
        default: begin
          case (kept)
            "jpeg": hit = FT_JPEG;
            "tiff": hit = FT_TIFF;
            "text": hit = FT_TEXT;
            "docx": hit = FT_DOCX;
            "pptx": hit = FT_PPTX;
            default: ;
          endcase
        end
      endcase
      return hit;
    endfunction

    // magic prefixes in priority order
    function file_type_e magic_lookup();
      if (head_count >= 4 && head_first[63:32] == "%PDF") return FT_PDF;
      if (head_count >= 4 && head_first[63:32] == "%!PS") return FT_PS;
      if (head_count >= 3 && head_first[63:40] == 24'hffd8ff) return FT_JPEG;
      if (head_count >= 8 && head_first == 64'h89504e470d0a1a0a) return FT_PNG;
      if (head_count >= 6 && (head_first[63:16] == "GIF87a" || head_first[63:16] == "GIF89a"))
        return FT_GIF;
      if (head_count >= 4 && (head_first[63:32] == 32'h49492a00 ||
                              head_first[63:32] == 32'h4d4d002a))
        return FT_TIFF;
      if (head_count >= 2 && head_first[63:48] == "BM") return FT_BMP;
      if (head_count >= 5 && head_first[63:24] == 40'h7b5c727466) return FT_RTF;
      if (head_count >= 4 && head_first[63:32] == 32'hd0cf11e0) return FT_MSWORD;
      return FT_UNKNOWN;
    endfunction

    function file_type_e sniff_head();
      file_type_e found;
      found = magic_lookup();
      if (found != FT_UNKNOWN) return found;
      if (svg_found) return FT_SVG;
      if (head_count == 0) return FT_UNKNOWN;
      return printable ? FT_TEXT : FT_UNKNOWN;
    endfunction

    function void take_byte(logic [7:0] c);
      if (head_count >= head_limit) return;
      if (head_count < 8) head_first[63 - 8 * head_count -: 8] = c;
      if (c < 8'h09 || (c > 8'h0d && c < 8'h20)) printable = 1'b0;
      if (!svg_found) begin
        if (svg_step < 4 && c == SVG_TAG[31 - 8 * svg_step -: 8]) svg_step++;
        else svg_step = (c == 8'h3c) ? 3'd1 : 3'd0;
        if (svg_step == 4) svg_found = 1'b1;
      end
      head_count++;
    endfunction

    function void note_request(logic [1:0] k, logic [1:0] mode, logic [31:0] chars,
                               logic [2:0] len, logic [7:0] b);
      case (k)
        fts_pkg::KIND_BEGIN: begin
          mode_q     = mode;
          suffix_hit = (mode == fts_pkg::MODE_CONTENT_ONLY) ? FT_UNKNOWN
                                                           : suffix_lookup(chars, len);
          clear_head();
        end
        fts_pkg::KIND_BYTE: take_byte(b);
        fts_pkg::KIND_END: begin
          if (suffix_hit != FT_UNKNOWN) expected_types.push_back(suffix_hit);
          else if (mode_q == fts_pkg::MODE_EXT_ONLY) expected_types.push_back(FT_UNKNOWN);
          else expected_types.push_back(sniff_head());
        end
        default: ;
      endcase
    endfunction

    function int pending();
      return expected_types.size();
    endfunction

    task report(string msg);
      errors++;
      $display("%0t mismatch: %s", $time, msg);
    endtask

    task check_type(logic [4:0] code);
      file_type_e want;
      if (expected_types.size() == 0) begin
        report($sformatf("type_code %0d with no end request outstanding", code));
        return;
      end
      want = expected_types.pop_front();
      if (code !== want)
        report($sformatf("type_code %0d, expected %0d (%s)", code, want, want.name()));
    endtask
  endclass

endpackage

// ===== verif/tb_top.sv =====
// top level testbench of the file type sniffer core
`timescale 1ns / 1ps
module tb_top;
  import tb_sniff_pkg::*;

  localparam int HEAD_LIMIT    = 512;
  localparam int RANDOM_ITEMS  = 1900;
  localparam int PHASES        = 6;
  localparam int CYCLE_LIMIT   = 300000;
  localparam int LONG_HOLD     = 200;
  localparam int SETTLE_CYCLES = 8;

  typedef enum int {SINK_FREE, SINK_RANDOM, SINK_HEAVY, SINK_PATTERN} sink_style_e;
  typedef enum int {HEAD_MAGIC, HEAD_SVG, HEAD_TEXT, HEAD_BINARY, HEAD_EMPTY} head_style_e;

  // stimulus seeds: suffixes left aligned, magic prefixes with their byte counts
  localparam logic [31:0] SUFFIX_SEEDS [23] = '{
    {"pdf", 8'h0}, {"ps", 16'h0}, {"jpg", 8'h0}, "jpeg", {"jpe", 8'h0}, {"png", 8'h0},
    {"gif", 8'h0}, {"tif", 8'h0}, "tiff", {"bmp", 8'h0}, {"svg", 8'h0}, {"txt", 8'h0},
    "text", {"log", 8'h0}, {"md", 16'h0}, {"csv", 8'h0}, {"doc", 8'h0}, "docx",
    {"rtf", 8'h0}, {"odt", 8'h0}, {"ppt", 8'h0}, "pptx", {"odp", 8'h0}
  };
  localparam logic [63:0] MAGIC_SEEDS [11] = '{
    64'h2550444600000000, 64'h2521505300000000, 64'hffd8ff0000000000,
    64'h89504e470d0a1a0a, 64'h4749463837610000, 64'h4749463839610000,
    64'h49492a0000000000, 64'h4d4d002a00000000, 64'h424d000000000000,
    64'h7b5c727466000000, 64'hd0cf11e000000000
  };
  localparam int MAGIC_SIZES [11] = '{4, 4, 3, 8, 6, 6, 4, 4, 2, 5, 4};
  // bytes around the control byte ranges, plus the extremes
  localparam logic [7:0] BOUNDARY_BYTES [9] = '{
    8'h00, 8'h08, 8'h09, 8'h0d, 8'h0e, 8'h1f, 8'h20, 8'h7f, 8'hff
  };

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [1:0]  kind         = '0;
  logic [1:0]  match_mode   = '0;
  logic [31:0] suffix_chars = '0;
  logic [2:0]  suffix_len   = '0;
  logic [7:0]  data_byte    = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [4:0]  type_code;

  sniff_scoreboard sb = new(HEAD_LIMIT);

  // sender pacing and receiver style, changed per phase
  int          max_gap     = 0;
  int          max_burst   = 1;
  int          burst_left  = 0;
  sink_style_e sink_style  = SINK_FREE;
  bit          long_hold_req = 1'b0;
  int          hold_left   = 0;
  logic [15:0] stall_pattern = 16'b1110_0010_0110_0001;
  logic [3:0]  pattern_pos = '0;
  int          sent_items  = 0;
  int          cycle_count = 0;
  logic [7:0]  head_q[$];
  string       svg_variants[7] = '{"<svg", "<<svg", "<sv<svg", "<s<svg", "<sv", "svg<svg",
                                   "<svG"};

  file_type_sniffer_core #(
    .HEAD_BYTES(HEAD_LIMIT)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .kind        (kind),
    .match_mode  (match_mode),
    .suffix_chars(suffix_chars),
    .suffix_len  (suffix_len),
    .data_byte   (data_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .type_code   (type_code)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // watchdog on the whole run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // handshake monitors: requests feed the predictor, results are checked in order
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall)
        sb.note_request(kind, match_mode, suffix_chars, suffix_len, data_byte);
      if (out_valid && !out_stall)
        sb.check_type(type_code);
    end
  end

  // result side: a long hold-off when asked, otherwise the style of the phase
  always @(negedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_left = LONG_HOLD;
    end
    pattern_pos <= pattern_pos + 4'd1;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (sink_style)
        SINK_FREE:   out_stall <= 1'b0;
        SINK_RANDOM: out_stall <= ($urandom_range(0, 3) == 0);
        SINK_HEAVY:  out_stall <= ($urandom_range(0, 9) < 7);
        default:     out_stall <= stall_pattern[pattern_pos];
      endcase
    end
  end

  task automatic set_pace(input int gap, input int burst, input sink_style_e sink);
    max_gap    = gap;
    max_burst  = burst;
    burst_left = 0;
    sink_style = sink;
  endtask

  // sender idle cycles, payload scrambled while valid is low
  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk);
      in_valid     <= 1'b0;
      kind         <= 2'($urandom);
      match_mode   <= 2'($urandom);
      suffix_chars <= $urandom;
      suffix_len   <= 3'($urandom);
      data_byte    <= 8'($urandom);
    end
  endtask

  // one request, held until accepted; gaps fall between bursts
  task automatic send_req(input logic [1:0] k, input logic [1:0] mode,
                          input logic [31:0] chars, input logic [2:0] len,
                          input logic [7:0] b);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, max_burst);
      if (max_gap > 0) idle_cycles($urandom_range(1, max_gap));
    end
    burst_left--;
    @(negedge clk);
    in_valid     <= 1'b1;
    kind         <= k;
    match_mode   <= mode;
    suffix_chars <= chars;
    suffix_len   <= len;
    data_byte    <= b;
    do @(posedge clk); while (in_stall);
    if (k != KIND_SPARE) sent_items++;
  endtask

  // fields the kind does not use are left random
  task automatic send_begin(input logic [1:0] mode, input logic [31:0] chars,
                            input logic [2:0] len);
    send_req(fts_pkg::KIND_BEGIN, mode, chars, len, 8'($urandom));
  endtask

  task automatic send_byte(input logic [7:0] b);
    send_req(fts_pkg::KIND_BYTE, 2'($urandom), $urandom, 3'($urandom), b);
  endtask

  task automatic send_end();
    send_req(fts_pkg::KIND_END, 2'($urandom), $urandom, 3'($urandom), 8'($urandom));
  endtask

  task automatic send_spare();
    send_req(KIND_SPARE, 2'($urandom), $urandom, 3'($urandom), 8'($urandom));
  endtask

  task automatic send_head();
    foreach (head_q[i]) send_byte(head_q[i]);
  endtask

  // sender pause until every outstanding result has been taken
  task automatic wait_drained();
    idle_cycles(1);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  function automatic logic [7:0] text_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 2) return BOUNDARY_BYTES[$urandom_range(0, 8)];
    if (r < 8) return 8'($urandom_range(9, 13));
    return 8'($urandom_range(8'h20, 8'h7e));
  endfunction

  task automatic build_head(input head_style_e style, input int head_len);
    int          idx;
    int          keep;
    int          at;
    bit          binary_tail;
    logic [63:0] magic;
    string       variant;
    head_q.delete();
    binary_tail = $urandom_range(0, 1);
    case (style)
      HEAD_MAGIC: begin
        idx   = $urandom_range(0, 10);
        magic = MAGIC_SEEDS[idx];
        keep  = MAGIC_SIZES[idx];
        // sometimes cut short or one bit off, so the prefix may just miss
        if ($urandom_range(0, 3) == 0) keep = $urandom_range(0, keep);
        if ($urandom_range(0, 5) == 0) magic[$urandom_range(0, 63)] ^= 1'b1;
        for (int i = 0; i < keep; i++) head_q.push_back(magic[63 - 8 * i -: 8]);
        while (head_q.size() < head_len)
          head_q.push_back(binary_tail ? 8'($urandom) : text_char());
      end
      HEAD_SVG: begin
        repeat (head_len) head_q.push_back(text_char());
        variant = svg_variants[$urandom_range(0, 6)];
        at = $urandom_range(0, head_len);
        for (int i = variant.len() - 1; i >= 0; i--) head_q.insert(at, variant[i]);
      end
      HEAD_TEXT:   repeat (head_len) head_q.push_back(text_char());
      HEAD_BINARY: repeat (head_len) head_q.push_back(8'($urandom));
      default: ;
    endcase
  endtask

  task automatic pick_suffix(output logic [31:0] chars, output logic [2:0] len);
    logic [31:0] base;
    int          r;
    base  = SUFFIX_SEEDS[$urandom_range(0, 22)];
    len   = (base[7:0] != 0) ? 3'd4 : (base[15:8] != 0) ? 3'd3 : 3'd2;
    chars = base;
    r     = $urandom_range(0, 99);
    if (r < 25)
      chars = base | ($urandom & (32'hffff_ffff >> (8 * len)));   // junk past the length
    else if (r < 40)
      chars[31 - $urandom_range(0, 8 * len - 1)] ^= 1'b1;         // near miss
    else if (r < 55)
      len = 3'($urandom_range(0, 7));                              // length off
    else if (r < 70) begin
      chars = $urandom;
      len   = 3'($urandom_range(0, 7));
    end
  endtask

  function automatic logic [1:0] pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return MODE_DEFAULT;
    if (r < 60) return fts_pkg::MODE_EXT_ONLY;
    if (r < 90) return fts_pkg::MODE_CONTENT_ONLY;
    return MODE_BOTH;
  endfunction

  // one random step: mostly whole files, some stray or broken sequences
  task automatic random_step();
    logic [31:0] chars;
    logic [2:0]  len;
    int          r;
    int          head_len;
    r = $urandom_range(0, 99);
    if (r < 85) begin
      pick_suffix(chars, len);
      head_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 60) : $urandom_range(0, 24);
      build_head(head_style_e'($urandom_range(0, 4)), head_len);
      send_begin(pick_mode(), chars, len);
      send_head();
      send_end();
    end else if (r < 89) begin
      // head keeps growing after an end, and a second end classifies it again
      build_head(head_style_e'($urandom_range(0, 3)), $urandom_range(1, 6));
      send_head();
      send_end();
    end else if (r < 93) begin
      repeat ($urandom_range(1, 3)) send_spare();
    end else if (r < 97) begin
      repeat ($urandom_range(1, 4)) send_byte(8'($urandom));
    end else begin
      send_end();
    end
  endtask

  initial begin
    repeat (9) @(negedge clk);
    rst <= 1'b0;

    // directed part
    set_pace(0, 1, SINK_FREE);
    send_end();                                          // nothing begun: empty head
    send_begin(MODE_DEFAULT, {"pdf", 8'hff}, 3'd3);      // junk byte past the suffix
    send_byte("B");
    send_byte("M");
    send_end();                                          // suffix beats the bmp magic
    send_begin(fts_pkg::MODE_CONTENT_ONLY, {"png", 8'h00}, 3'd3);
    send_byte(8'h25);
    send_byte(8'h21);
    send_byte(8'h50);
    send_byte(8'h53);
    send_byte(8'h00);
    send_end();                                          // suffix ignored, postscript magic
    send_begin(fts_pkg::MODE_EXT_ONLY, 32'h0, 3'd5);     // suffix too long
    send_byte(8'hff);
    send_end();
    send_begin(MODE_BOTH, 32'hffff_ffff, 3'd0);          // empty suffix, mode three
    send_byte("%");
    send_end();                                          // one clean byte: text
    send_spare();
    send_byte("P");
    send_byte("D");
    send_byte("F");
    send_end();                                          // same head, now a pdf
    wait_drained();
    sent_items = 0;

    // random part in phases of different pacing
    for (int ph = 0; ph < PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: set_pace(0, 1, SINK_FREE);
        1: set_pace(3, 8, SINK_RANDOM);
        2: set_pace(6, 3, SINK_HEAVY);
        3: set_pace(0, 1, SINK_PATTERN);
        4: set_pace(2, 16, SINK_HEAVY);
        default: set_pace(4, 6, SINK_RANDOM);
      endcase
      if (ph == 1) begin
        // head past the limit: the tag completes and a control byte lands beyond it
        head_q.delete();
        repeat (HEAD_LIMIT - 4) head_q.push_back(8'($urandom_range(8'h20, 8'h7e)));
        head_q.push_back("<");
        head_q.push_back("s");
        head_q.push_back("v");
        head_q.push_back("g");
        head_q.push_back(8'h00);
        send_begin(fts_pkg::MODE_CONTENT_ONLY, $urandom, 3'($urandom));
        send_head();
        send_end();
      end
      // receiver holds off while files keep coming, so the input backs up
      if (ph == 3) long_hold_req = 1'b1;
      while (sent_items < (ph + 1) * RANDOM_ITEMS / PHASES) random_step();
    end

    // wind down
    idle_cycles(1);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
